[rtl/lpht_pkg.sv]
// lpht_pkg: shared types and constants of the linear probing hash table
// no dependencies; imported by the top level

package lpht_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP       = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BELOW_MIN = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_FIN
  } fsm_t;

  // slot marks held in the tag memory
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CAP = 2'd0;
  localparam logic [1:0] REG_MIN = 2'd1;

  localparam logic [4:0] CAP_RESET = 5'd16;
  localparam logic [4:0] MIN_RESET = 5'd0;

  localparam int KEY_W = 32;

  // record payload, one memory word per slot
  typedef struct packed {
    logic [7:0]  grade_c;
    logic [7:0]  grade_b;
    logic [7:0]  grade_a;
    logic [15:0] course_c;
    logic [15:0] course_b;
    logic [15:0] course_a;
    logic [11:0] year;
  } rec_t;

endpackage

[rtl/linear_probe_hash_table.sv]
// Open-addressing hash table with linear probing and tombstones, keyed by a
// 32-bit record key. One operation (insert, lookup, delete, or a no-op) is
// in work at a time and each gives exactly one result transaction. An
// operation is accepted, then the probe walk reads the tag memory at one slot
// per cycle (up to TABLE_SIZE slots), then the write back is done and the
// result presented once the output register is free. When TABLE_SIZE is
// not a power of two the home slot comes from a reciprocal multiply done as
// a low partial product, a high partial product and the remainder, ahead
// of the walk. Refused inserts and deletes, and no-ops, skip the walk.
// The next operation is accepted while the previous result still waits on
// the output.
// Depends on lpht_pkg and lpht_ram.

module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // record_key, entry_year, first_course, first_grade, second_course,
  // second_grade, third_course, third_grade, zero pad
  input  logic [119:0] in_tdata,
  // op
  input  logic [1:0]   in_tuser,
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // slot_index, entry_total, is_full, found_year, found_course_a,
  // found_grade_a, found_course_b, found_grade_b, found_course_c,
  // found_grade_c, zero pad
  output logic [95:0]  out_tdata,
  // status
  output logic [2:0]   out_tuser,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [4:0]   cfg_data
);

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
  localparam bit IS_POW2 = (TABLE_SIZE == (1 << IDX_W));
  localparam int SLOT_XW = (IDX_W > 4) ? IDX_W : 4;
  localparam int TAG_W   = 2 + KEY_W;
  localparam int REC_W   = $bits(rec_t);

  // reciprocal of TABLE_SIZE, exact quotient for every 32-bit key
  localparam int HASH_SH = KEY_W + IDX_W;
  localparam logic [63:0] RECIP = ((64'd1 << HASH_SH) + 64'(TABLE_SIZE) - 64'd1)
                                  / 64'(TABLE_SIZE);
  localparam logic [15:0] RECIP_LO = RECIP[15:0];
  localparam logic [16:0] RECIP_HI = RECIP[32:16];
  localparam logic [IDX_W-1:0] SIZE_LO = IDX_W'(TABLE_SIZE);

  // ---------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------
  fsm_t             state_r, state_nxt;
  logic [4:0]       cap_r, cap_nxt;
  logic [4:0]       min_r, min_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [TABLE_SIZE-1:0] vld_r, vld_nxt;

  op_t              op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  rec_t             rec_r, rec_nxt;
  logic             skip_r, skip_nxt;

  logic [65:0]      hash_acc_r, hash_acc_nxt;
  logic [1:0]       hash_step_r, hash_step_nxt;

  logic [IDX_W-1:0] pr_addr_r, pr_addr_nxt;
  logic [CNT_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic             q_vld_r, q_vld_nxt;
  logic             q_last_r, q_last_nxt;
  logic [IDX_W-1:0] q_addr_r;

  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_slot_r, hit_slot_nxt;
  logic             free_seen_r, free_seen_nxt;
  logic [IDX_W-1:0] free_slot_r, free_slot_nxt;
  rec_t             found_r, found_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [95:0]      out_data_r, out_data_nxt;
  logic [2:0]       out_user_r, out_user_nxt;

  // memory ports
  logic             tag_we;
  logic [IDX_W-1:0] tag_waddr;
  logic [TAG_W-1:0] tag_wdata;
  logic [TAG_W-1:0] tag_rdata;
  logic             rec_we;
  logic [REC_W-1:0] rec_rdata;

  // ---------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------
  logic             in_acc;
  op_t              in_op;
  logic [47:0]      hash_pp_lo;
  logic [48:0]      hash_pp_hi;
  logic [IDX_W-1:0] hash_q_lo;
  logic [IDX_W-1:0] hash_slot;
  logic             q_live, q_empty, q_key_eq;
  logic             stop_hit, stop_miss;
  logic             fin_go;
  logic             ins_ok, del_ok;
  logic [4:0]       cnt_after;
  status_t          fin_status;
  logic [IDX_W-1:0] fin_slot;
  logic [SLOT_XW-1:0] fin_slot_x;
  rec_t             fin_rec;

  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = op_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // home slot = key - floor(key * RECIP >> HASH_SH) * TABLE_SIZE, low bits only
  assign hash_pp_lo = 48'(key_r) * 48'(RECIP_LO);
  assign hash_pp_hi = 49'(key_r) * 49'(RECIP_HI);
  assign hash_q_lo  = hash_acc_r[HASH_SH +: IDX_W];
  assign hash_slot  = key_r[IDX_W-1:0] - hash_q_lo * SIZE_LO;

  // slot under evaluation; a slot never written reads as empty
  assign q_live    = vld_r[q_addr_r] && (tag_rdata[TAG_W-1 -: 2] == MARK_LIVE);
  assign q_empty   = !vld_r[q_addr_r] || (tag_rdata[TAG_W-1 -: 2] == MARK_EMPTY);
  assign q_key_eq  = (tag_rdata[KEY_W-1:0] == key_r);
  assign stop_hit  = (state_r == S_PROBE) && q_vld_r && q_live && q_key_eq;
  assign stop_miss = (state_r == S_PROBE) && q_vld_r && !(q_live && q_key_eq)
                     && (q_empty || q_last_r);

  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign ins_ok = (op_r == OP_INSERT) && !skip_r && !hit_r && free_seen_r;
  assign del_ok = (op_r == OP_DELETE) && !skip_r && hit_r;

  always_comb begin
    cnt_after = cnt_r;
    if (ins_ok) begin
      cnt_after = cnt_r + 5'd1;
    end else if (del_ok) begin
      cnt_after = cnt_r - 5'd1;
    end
  end

  always_comb begin
    fin_status = ST_OK;
    fin_slot   = '0;
    fin_rec    = '0;
    case (op_r)
      OP_INSERT: begin
        if (skip_r || (!hit_r && !free_seen_r)) begin
          fin_status = ST_FULL;
        end else if (hit_r) begin
          fin_status = ST_DUP;
        end else begin
          fin_slot = free_slot_r;
        end
      end
      OP_LOOKUP: begin
        if (hit_r) begin
          fin_slot = hit_slot_r;
          fin_rec  = found_r;
        end else begin
          fin_status = ST_NOT_FOUND;
        end
      end
      OP_DELETE: begin
        if (skip_r) begin
          fin_status = ST_BELOW_MIN;
        end else if (hit_r) begin
          fin_slot = hit_slot_r;
        end else begin
          fin_status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  assign fin_slot_x = SLOT_XW'(fin_slot);

  // write back: insert places a live record, delete leaves a tombstone
  assign tag_we    = fin_go && (ins_ok || del_ok);
  assign tag_waddr = ins_ok ? free_slot_r : hit_slot_r;
  assign tag_wdata = {(ins_ok ? MARK_LIVE : MARK_TOMB), key_r};
  assign rec_we    = fin_go && ins_ok;

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    min_nxt       = min_r;
    cnt_nxt       = cnt_r;
    vld_nxt       = vld_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    rec_nxt       = rec_r;
    skip_nxt      = skip_r;
    hash_acc_nxt  = hash_acc_r;
    hash_step_nxt = hash_step_r;
    pr_addr_nxt   = pr_addr_r;
    iss_cnt_nxt   = iss_cnt_r;
    q_vld_nxt     = 1'b0;
    q_last_nxt    = q_last_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    free_seen_nxt = free_seen_r;
    free_slot_nxt = free_slot_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CAP: cap_nxt = cfg_data;
        REG_MIN: min_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_op;
          key_nxt       = in_tdata[31:0];
          rec_nxt.year     = in_tdata[43:32];
          rec_nxt.course_a = in_tdata[59:44];
          rec_nxt.grade_a  = in_tdata[67:60];
          rec_nxt.course_b = in_tdata[83:68];
          rec_nxt.grade_b  = in_tdata[91:84];
          rec_nxt.course_c = in_tdata[107:92];
          rec_nxt.grade_c  = in_tdata[115:108];
          hit_nxt       = 1'b0;
          free_seen_nxt = 1'b0;
          skip_nxt      = ((in_op == OP_INSERT) && (cnt_r >= cap_r))
                       || ((in_op == OP_DELETE) && (cnt_r <= min_r))
                       || (in_op == OP_NOP);
          hash_step_nxt = '0;
          pr_addr_nxt   = in_tdata[IDX_W-1:0];
          iss_cnt_nxt   = '0;
          if (skip_nxt) begin
            state_nxt = S_FIN;
          end else if (IS_POW2) begin
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end

      S_HASH: begin
        // low partial product, then high partial product, then the remainder
        hash_step_nxt = hash_step_r + 2'd1;
        case (hash_step_r)
          2'd0: hash_acc_nxt = 66'(hash_pp_lo);
          2'd1: hash_acc_nxt = hash_acc_r + 66'({hash_pp_hi, 16'b0});
          default: begin
            pr_addr_nxt = hash_slot;
            state_nxt   = S_PROBE;
          end
        endcase
      end

      S_PROBE: begin
        // issue one read per cycle, evaluate the read issued in the previous cycle
        if (iss_cnt_r != CNT_W'(TABLE_SIZE)) begin
          q_vld_nxt   = 1'b1;
          q_last_nxt  = (iss_cnt_r == CNT_W'(TABLE_SIZE - 1));
          iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
          pr_addr_nxt = (pr_addr_r == IDX_W'(TABLE_SIZE - 1))
                        ? '0 : pr_addr_r + IDX_W'(1);
        end
        if (q_vld_r) begin
          // first non-live slot on the path is where an insert lands
          if (!q_live && !free_seen_r) begin
            free_seen_nxt = 1'b1;
            free_slot_nxt = q_addr_r;
          end
          if (stop_hit) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = q_addr_r;
            found_nxt    = rec_t'(rec_rdata);
            state_nxt    = S_FIN;
          end else if (stop_miss) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = fin_status;
          out_data_nxt  = {2'b00,
                           fin_rec.grade_c, fin_rec.course_c,
                           fin_rec.grade_b, fin_rec.course_b,
                           fin_rec.grade_a, fin_rec.course_a,
                           fin_rec.year,
                           (cnt_after >= cap_r), cnt_after,
                           fin_slot_x[3:0]};
          cnt_nxt = cnt_after;
          if (tag_we) begin
            vld_nxt[tag_waddr] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      min_r       <= MIN_RESET;
      cnt_r       <= '0;
      vld_r       <= '0;
      q_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      min_r       <= min_nxt;
      cnt_r       <= cnt_nxt;
      vld_r       <= vld_nxt;
      q_vld_r     <= q_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    rec_r       <= rec_nxt;
    skip_r      <= skip_nxt;
    hash_acc_r  <= hash_acc_nxt;
    hash_step_r <= hash_step_nxt;
    pr_addr_r   <= pr_addr_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    q_last_r    <= q_last_nxt;
    q_addr_r    <= pr_addr_r;
    hit_r       <= hit_nxt;
    hit_slot_r  <= hit_slot_nxt;
    free_seen_r <= free_seen_nxt;
    free_slot_r <= free_slot_nxt;
    found_r     <= found_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------------------------------------------------------------
  // memories: tag (mark and key) and record payload, same read address
  // ---------------------------------------------------------------------
  lpht_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TABLE_SIZE)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (pr_addr_r),
    .rdata (tag_rdata)
  );

  lpht_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_SIZE)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (free_slot_r),
    .wdata (rec_r),
    .raddr (pr_addr_r),
    .rdata (rec_rdata)
  );

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_mem_write_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_we || rec_we) |-> (state_r == S_FIN))
    else $error("memory written outside write-back");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 ((cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + 5'd1)
         || (cnt_r == $past(cnt_r) - 5'd1)))
    else $error("live count moved by more than one");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= TABLE_SIZE)
    else $error("live count exceeds table size");

  a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    rec_we |-> (!vld_r[free_slot_r] || !hit_r))
    else $error("insert write back onto a matching live slot");

endmodule

[rtl/lpht_ram.sv]
// lpht_ram: generic single write port, single read port memory
// registered read; no dependencies

module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
